[rtl/aas_pkg.sv]
// ----------------------------------------------------------------------------
// Auction solver package
// Shared constants and the cell control type for the auction assignment solver.
// ----------------------------------------------------------------------------
package aas_pkg;

	localparam int DEF_MAX_SIZE = 16;

	// Configuration register indexes (byte address = 4 * index).
	localparam logic [1:0] REG_SIZE   = 2'd0;
	localparam logic [1:0] REG_EPS    = 2'd1;
	localparam logic [1:0] REG_ROUNDS = 2'd2;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	// Commands from the sequencer to every cell of the item chain.
	typedef struct packed {
		logic clear_all;    // auction start: price zero, no owner
		logic clear_round;  // forget the best bid seen in the last round
		logic resolve;      // hand each item to its best bidder
	} cell_ctl_t;

endpackage

[rtl/aas_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aas_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/aas_cell.sv]
// ----------------------------------------------------------------------------
// Item cell
// Holds one item's price and owner, watches the passing bid stream for bids
// on its item and keeps the best, then settles the item on resolve.
// ----------------------------------------------------------------------------
module aas_cell #(
	parameter int INDEX = 0,
	parameter int IW    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  aas_pkg::cell_ctl_t ctl,
	input  logic               tok_valid_in,
	input  logic [IW-1:0]      tok_bidder_in,
	input  logic [IW-1:0]      tok_target_in,
	input  logic [31:0]        tok_amount_in,
	output logic               tok_valid_out,
	output logic [IW-1:0]      tok_bidder_out,
	output logic [IW-1:0]      tok_target_out,
	output logic [31:0]        tok_amount_out,
	output logic               owned,
	output logic [IW-1:0]      owner,
	output logic [31:0]        price,
	output logic               win,
	output logic [IW-1:0]      win_bidder
);

	logic          owned_q;
	logic [IW-1:0] owner_q;
	logic [31:0]   price_q;
	logic          best_valid_q;
	logic [IW-1:0] best_bidder_q;
	logic [31:0]   best_amt_q;
	logic [32:0]   price_sum;
	logic          hit;

	assign hit = tok_valid_in && (tok_target_in == IW'(INDEX))
		&& (!best_valid_q || (tok_amount_in > best_amt_q));
	assign price_sum = {1'b0, price_q} + {1'b0, best_amt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owned_q       <= 1'b0;
			best_valid_q  <= 1'b0;
			tok_valid_out <= 1'b0;
		end else begin
			tok_valid_out <= tok_valid_in;
			if (ctl.clear_all) begin
				owned_q      <= 1'b0;
				best_valid_q <= 1'b0;
			end else if (ctl.clear_round) begin
				best_valid_q <= 1'b0;
			end else if (ctl.resolve) begin
				if (best_valid_q) begin
					owned_q <= 1'b1;
				end
			end else if (hit) begin
				best_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_bidder_out <= tok_bidder_in;
		tok_target_out <= tok_target_in;
		tok_amount_out <= tok_amount_in;
		if (ctl.clear_all) begin
			price_q <= '0;
		end else if (ctl.resolve) begin
			if (best_valid_q) begin
				owner_q <= best_bidder_q;
				price_q <= price_sum[32] ? aas_pkg::SAT32 : price_sum[31:0];
			end
		end else if (hit) begin
			best_bidder_q <= tok_bidder_in;
			best_amt_q    <= tok_amount_in;
		end
	end

	assign owned      = owned_q;
	assign owner      = owner_q;
	assign price      = price_q;
	assign win        = best_valid_q;
	assign win_bidder = best_bidder_q;

endmodule

[rtl/auction_assignment_solver.sv]
// ----------------------------------------------------------------------------
// Auction assignment solver
// Loads a square benefit matrix and solves the assignment by Jacobi auction.
// ----------------------------------------------------------------------------
// Benefit entries are taken one per cycle into a matrix RAM; the request that
// carries load_done starts the auction over the first size_in_use bidders and
// items, and no new request is taken until every bidder's result has been
// handed out (the last result may still wait while the next load begins).
// A round scans each unassigned bidder's row, one item per cycle from the
// matrix RAM, and passes over each assigned bidder; each bid then travels
// down a chain of MAX_SIZE item cells, each of which keeps the best bid for
// its own item. After the chain drains, all cells settle at once. The number
// of rounds depends on the benefits and epsilon, bounded by round_limit.
// Results come one per cycle while out_ready stays high. No clearing pass is
// needed after reset.
module auction_assignment_solver #(
	parameter int MAX_SIZE = aas_pkg::DEF_MAX_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  row_bidder,
	input  logic [3:0]  col_item,
	input  logic signed [15:0] benefit,
	input  logic        load_done,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  bidder_id,
	output logic [4:0]  won_item,
	output logic [31:0] paid_price,
	output logic        status,
	output logic        final_result
);

	localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int NW = $clog2(MAX_SIZE + 1);
	localparam int AW = 2 * IW;

	typedef enum logic [3:0] {
		ST_LOAD, ST_START, ST_ROUND_CHK, ST_BID_SEL, ST_BID_SCAN, ST_BID_WAIT,
		ST_BID_PUSH, ST_FLUSH, ST_RESOLVE, ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [4:0]  size_q;
	logic [7:0]  eps_q;
	logic [15:0] limit_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= 5'd16;
			eps_q   <= 8'd1;
			limit_q <= 16'hFFFF;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				aas_pkg::REG_SIZE:   size_q  <= pwdata[4:0];
				aas_pkg::REG_EPS:    eps_q   <= pwdata[7:0];
				aas_pkg::REG_ROUNDS: limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			aas_pkg::REG_SIZE:   prdata = {27'd0, size_q};
			aas_pkg::REG_EPS:    prdata = {24'd0, eps_q};
			aas_pkg::REG_ROUNDS: prdata = {16'd0, limit_q};
			default:             prdata = '0;
		endcase
	end

	// Size in use, held to the range 1..MAX_SIZE.
	logic [NW-1:0] n_w;
	always_comb begin
		if (size_q == 5'd0) begin
			n_w = NW'(1);
		end else if (32'(size_q) > MAX_SIZE) begin
			n_w = NW'(MAX_SIZE);
		end else begin
			n_w = NW'(size_q);
		end
	end

	// Benefit matrix RAM, addressed by {bidder, item}.
	logic [IW+3:0]  row_x, col_x;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [15:0]    ram_rdata;

	assign row_x     = {{IW{1'b0}}, row_bidder};
	assign col_x     = {{IW{1'b0}}, col_item};
	assign in_ready  = (state_q == ST_LOAD);
	assign ram_we    = in_valid && in_ready && (32'(row_bidder) < MAX_SIZE)
		&& (32'(col_item) < MAX_SIZE);
	assign ram_waddr = {row_x[IW-1:0], col_x[IW-1:0]};

	aas_ram #(.WIDTH(16), .DEPTH(2 ** AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (benefit),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Item cell chain.
	aas_pkg::cell_ctl_t ctl;
	logic              tok_v   [MAX_SIZE+1];
	logic [IW-1:0]     tok_b   [MAX_SIZE+1];
	logic [IW-1:0]     tok_t   [MAX_SIZE+1];
	logic [31:0]       tok_a   [MAX_SIZE+1];
	logic              c_owned [MAX_SIZE];
	logic [IW-1:0]     c_owner [MAX_SIZE];
	logic [31:0]       c_price [MAX_SIZE];
	logic              c_win   [MAX_SIZE];
	logic [IW-1:0]     c_winb  [MAX_SIZE];

	for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
		aas_cell #(.INDEX(k), .IW(IW)) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.tok_valid_in   (tok_v[k]),
			.tok_bidder_in  (tok_b[k]),
			.tok_target_in  (tok_t[k]),
			.tok_amount_in  (tok_a[k]),
			.tok_valid_out  (tok_v[k+1]),
			.tok_bidder_out (tok_b[k+1]),
			.tok_target_out (tok_t[k+1]),
			.tok_amount_out (tok_a[k+1]),
			.owned          (c_owned[k]),
			.owner          (c_owner[k]),
			.price          (c_price[k]),
			.win            (c_win[k]),
			.win_bidder     (c_winb[k])
		);
	end

	// An item among the first n that nobody owns keeps the auction going.
	logic any_unowned;
	always_comb begin
		any_unowned = 1'b0;
		for (int k = 0; k < MAX_SIZE; k++) begin
			if ((k < 32'(n_w)) && !c_owned[k]) begin
				any_unowned = 1'b1;
			end
		end
	end

	// Bidder flags after the cells settle: displaced owners lose, winners gain.
	logic [MAX_SIZE-1:0] assigned_q, assigned_nxt;
	always_comb begin
		assigned_nxt = assigned_q;
		for (int k = 0; k < MAX_SIZE; k++) begin
			if (c_win[k] && c_owned[k]) begin
				assigned_nxt[c_owner[k]] = 1'b0;
			end
		end
		for (int k = 0; k < MAX_SIZE; k++) begin
			if (c_win[k]) begin
				assigned_nxt[c_winb[k]] = 1'b1;
			end
		end
	end

	// Row scan of one bidder: read data arrives in the cycle after its address.
	logic [NW-1:0]       b_q;
	logic [IW-1:0]       i_q;
	logic                rd_valid_s1;
	logic [IW-1:0]       rd_item_s1;
	logic signed [33:0]  best1_q, best2_q, val;
	logic                second_q;
	logic [IW-1:0]       pick_q;
	logic signed [34:0]  bid_raw;
	logic [31:0]         bid;
	logic [15:0]         rounds_q;
	logic [7:0]          flush_q;
	logic                status_q;
	logic                last_item;

	assign ram_raddr = {b_q[IW-1:0], i_q};
	assign last_item = (NW'(i_q) == n_w - NW'(1));
	assign val = 34'($signed(ram_rdata)) - $signed({2'b00, c_price[rd_item_s1]});
	assign bid_raw = 35'(best1_q) - 35'(best2_q) + $signed({27'd0, eps_q});

	always_comb begin
		if (n_w == NW'(1)) begin
			bid = {24'd0, eps_q};
		end else if (bid_raw[34:32] != 3'd0) begin
			bid = aas_pkg::SAT32;
		end else begin
			bid = bid_raw[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			if (rd_item_s1 == '0) begin
				best1_q  <= val;
				pick_q   <= rd_item_s1;
				second_q <= 1'b0;
			end else if (val > best1_q) begin
				best2_q  <= best1_q;
				best1_q  <= val;
				pick_q   <= rd_item_s1;
				second_q <= 1'b1;
			end else if (!second_q || (val > best2_q)) begin
				best2_q  <= val;
				second_q <= 1'b1;
			end
		end
	end

	// Result lookup: the item owned by the bidder being reported.
	logic [4:0]  look_item;
	logic [31:0] look_price;
	always_comb begin
		look_item  = 5'(MAX_SIZE);
		look_price = '0;
		for (int k = 0; k < MAX_SIZE; k++) begin
			if ((k < 32'(n_w)) && c_owned[k] && (NW'(c_owner[k]) == b_q)) begin
				look_item  = 5'(k);
				look_price = c_price[k];
			end
		end
	end

	// Sequencer with the bid injection register and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			ctl         <= '0;
			tok_v[0]    <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid   <= 1'b0;
			assigned_q  <= '0;
			b_q         <= '0;
			i_q         <= '0;
			rounds_q    <= '0;
			flush_q     <= '0;
			status_q    <= 1'b0;
		end else begin
			ctl         <= '0;
			tok_v[0]    <= 1'b0;
			rd_valid_s1 <= 1'b0;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_valid && load_done) begin
						ctl.clear_all <= 1'b1;
						state_q       <= ST_START;
					end
				end
				ST_START: begin
					assigned_q <= '0;
					rounds_q   <= '0;
					state_q    <= ST_ROUND_CHK;
				end
				ST_ROUND_CHK: begin
					b_q <= '0;
					if (!any_unowned || (rounds_q >= limit_q)) begin
						status_q <= any_unowned;
						state_q  <= ST_EMIT;
					end else begin
						ctl.clear_round <= 1'b1;
						state_q         <= ST_BID_SEL;
					end
				end
				ST_BID_SEL: begin
					i_q <= '0;
					if (b_q == n_w) begin
						flush_q <= '0;
						state_q <= ST_FLUSH;
					end else if (assigned_q[b_q[IW-1:0]]) begin
						b_q <= b_q + NW'(1);
					end else begin
						state_q <= ST_BID_SCAN;
					end
				end
				ST_BID_SCAN: begin
					rd_valid_s1 <= 1'b1;
					rd_item_s1  <= i_q;
					if (last_item) begin
						state_q <= ST_BID_WAIT;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_BID_WAIT: begin
					state_q <= ST_BID_PUSH;
				end
				ST_BID_PUSH: begin
					tok_v[0] <= 1'b1;
					tok_b[0] <= b_q[IW-1:0];
					tok_t[0] <= pick_q;
					tok_a[0] <= bid;
					b_q      <= b_q + NW'(1);
					state_q  <= ST_BID_SEL;
				end
				ST_FLUSH: begin
					flush_q <= flush_q + 8'd1;
					if (32'(flush_q) == MAX_SIZE) begin
						ctl.resolve <= 1'b1;
						state_q     <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					assigned_q <= assigned_nxt;
					rounds_q   <= rounds_q + 16'd1;
					state_q    <= ST_ROUND_CHK;
				end
				ST_EMIT: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						bidder_id    <= 4'(b_q);
						won_item     <= look_item;
						paid_price   <= look_price;
						status       <= status_q;
						final_result <= (b_q == n_w - NW'(1));
						b_q          <= b_q + NW'(1);
						if (b_q == n_w - NW'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

[rtl/aas_checker.sv]
// ----------------------------------------------------------------------------
// Auction solver port checker
// Watches the ports of the solver for ordering and result consistency.
// ----------------------------------------------------------------------------
module aas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  bidder_id,
	input logic [4:0]  won_item,
	input logic [31:0] paid_price,
	input logic        status,
	input logic        final_result
);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bidder_id)
			&& $stable(won_item) && $stable(paid_price))
		else $error("stalled result changed");

	// No new request is taken while results other than the last are pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_result |-> !in_ready)
		else $error("request taken during result output");

	// A fully assigned run gives every bidder an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> won_item != 5'd16)
		else $error("bidder without item in a complete run");

	// The configuration port never waits.
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind auction_assignment_solver aas_checker u_aas_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.bidder_id    (bidder_id),
	.won_item     (won_item),
	.paid_price   (paid_price),
	.status       (status),
	.final_result (final_result)
);

[bench/auction_assignment_solver_tb.sv]
// ----------------------------------------------------------------------------
// Auction assignment solver testbench
// Loads benefit matrices, runs auctions under many register settings and
// checks every bidder's result against an in-bench auction predictor.
// ----------------------------------------------------------------------------
module auction_assignment_solver_tb;

	localparam int N_MAX = aas_pkg::DEF_MAX_SIZE;
	localparam int NO_ITEM = N_MAX;
	localparam int WATCHDOG_LIMIT = 100000000;
	localparam int ITEM_TARGET = 500;

	// One bidder's outcome as the block should report it.
	typedef struct {
		logic [3:0]  bidder;
		logic [4:0]  item;
		logic [31:0] price;
		logic        stat;
		logic        last;
	} award_t;

	// The scoreboard keeps its own copy of the benefit matrix and registers.
	// A request with load_done set runs the whole auction at once and queues
	// one award per bidder, oldest first.
	class assignment_scoreboard;
		logic signed [15:0] ben[N_MAX][N_MAX];
		logic [4:0]  size_reg = 5'd16;
		logic [7:0]  eps_reg = 8'd1;
		logic [15:0] round_reg = 16'hFFFF;
		award_t      awards[$];

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			if (idx == aas_pkg::REG_SIZE) size_reg = val[4:0];
			else if (idx == aas_pkg::REG_EPS) eps_reg = val[7:0];
			else if (idx == aas_pkg::REG_ROUNDS) round_reg = val[15:0];
		endfunction

		function void note_request(logic [3:0] row, logic [3:0] col,
				logic signed [15:0] b, logic done);
			longint unsigned price[N_MAX];
			int owner[N_MAX];
			bit owned[N_MAX];
			bit bidding[N_MAX];
			int target[N_MAX];
			longint unsigned amount[N_MAX];
			int n, rounds, win, pick;
			bit open_item;
			longint best1, best2, v, bid;
			longint unsigned top, p;
			award_t a;
			ben[row][col] = b;
			if (!done) return;
			n = (size_reg == 0) ? 1 : (size_reg > N_MAX ? N_MAX : size_reg);
			for (int i = 0; i < N_MAX; i++) begin
				price[i] = 0;
				owner[i] = NO_ITEM;
				owned[i] = 0;
			end
			rounds = 0;
			forever begin
				open_item = 0;
				for (int i = 0; i < n; i++)
					if (owner[i] == NO_ITEM) open_item = 1;
				if (!open_item || rounds >= round_reg) break;
				// Bidding: every free bidder targets its best net value.
				for (int bd = 0; bd < n; bd++) begin
					bidding[bd] = !owned[bd];
					if (!bidding[bd]) continue;
					best1 = 0;
					best2 = 0;
					pick = 0;
					for (int i = 0; i < n; i++) begin
						v = longint'(ben[bd][i]) - longint'(price[i]);
						if (i == 0 || v > best1) begin
							best2 = best1;
							best1 = v;
							pick = i;
						end else if (i == 1 || v > best2) begin
							best2 = v;
						end
					end
					bid = (n == 1) ? longint'(eps_reg) : best1 - best2 + longint'(eps_reg);
					if (bid > 64'sh0FFFF_FFFF) bid = 64'sh0FFFF_FFFF;
					target[bd] = pick;
					amount[bd] = longint'(bid);
				end
				// Assignment: highest bid wins, lowest bidder on ties.
				for (int i = 0; i < n; i++) begin
					win = NO_ITEM;
					top = 0;
					for (int bd = 0; bd < n; bd++)
						if (bidding[bd] && target[bd] == i && (win == NO_ITEM || amount[bd] > top)) begin
							win = bd;
							top = amount[bd];
						end
					if (win == NO_ITEM) continue;
					if (owner[i] != NO_ITEM) owned[owner[i]] = 0;
					p = price[i] + top;
					price[i] = (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
					owner[i] = win;
					owned[win] = 1;
				end
				rounds++;
			end
			open_item = 0;
			for (int i = 0; i < n; i++)
				if (owner[i] == NO_ITEM) open_item = 1;
			for (int bd = 0; bd < n; bd++) begin
				a.bidder = bd[3:0];
				a.item = 5'(NO_ITEM);
				a.price = 0;
				for (int i = 0; i < n; i++)
					if (owner[i] == bd) begin
						a.item = i[4:0];
						a.price = price[i][31:0];
					end
				a.stat = open_item;
				a.last = (bd == n - 1);
				awards.push_back(a);
			end
		endfunction

		// Returns 1 when the result matches; otherwise why names the bad fields, or the unexpected result.
		function bit check_result(award_t got, output string why);
			award_t w;
			why = "";
			if (awards.size() == 0) begin
				why = $sformatf("unexpected result for bidder %0d", got.bidder);
				return 0;
			end
			w = awards.pop_front();
			if (got.bidder !== w.bidder)
				why = {why, $sformatf(" bidder_id %0d/%0d", got.bidder, w.bidder)};
			if (got.item !== w.item)
				why = {why, $sformatf(" won_item %0d/%0d", got.item, w.item)};
			if (got.price !== w.price)
				why = {why, $sformatf(" paid_price %0h/%0h", got.price, w.price)};
			if (got.stat !== w.stat)
				why = {why, $sformatf(" status %0b/%0b", got.stat, w.stat)};
			if (got.last !== w.last)
				why = {why, $sformatf(" final_result %0b/%0b", got.last, w.last)};
			if (why != "") why = {"bidder ", $sformatf("%0d", w.bidder), " (got/exp):", why};
			return why == "";
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [3:0]  row_bidder, col_item;
	logic signed [15:0] benefit;
	logic        load_done;
	logic        out_valid, out_ready;
	logic [3:0]  bidder_id;
	logic [4:0]  won_item;
	logic [31:0] paid_price;
	logic        status, final_result;

	assignment_scoreboard book;
	int errors = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	bit hold_receiver = 0;

	auction_assignment_solver DUT (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report_mismatch(string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	// Result monitor. Outputs are read at the edge, so the values seen are the
	// ones that were present when the request was taken.
	always @(posedge clk) begin
		award_t got;
		string why;
		if (arst_n && out_valid && out_ready) begin
			got.bidder = bidder_id;
			got.item = won_item;
			got.price = paid_price;
			got.stat = status;
			got.last = final_result;
			if (!book.check_result(got, why)) report_mismatch(why);
		end
	end

	// The watchdog only counts cycles in which neither side moves a request.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("auction_assignment_solver_tb: done, errors");
			$finish;
		end
	end

	// Receiver: ready runs of random length broken by mostly short stalls.
	// On request it holds off for a long stretch so the solver backs up.
	initial begin
		int run_len, gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_receiver = 0;
			end
			out_ready <= 1'b1;
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
			repeat (run_len - 1) @(posedge clk);
			gap = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
			if (gap > 0) begin
				@(posedge clk);
				out_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end
		end
	end

	// Register write: a setup phase, then an access phase. Called at an edge.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		book.set_reg(idx, val);
	endtask

	// Offers one request and returns at the edge where it was taken, then
	// idles for a random gap (mostly none, now and then a long one).
	task automatic send_entry(logic [3:0] row, logic [3:0] col, logic signed [15:0] b,
			logic done);
		int gap;
		in_valid <= 1'b1;
		row_bidder <= row;
		col_item <= col;
		benefit <= b;
		load_done <= done;
		do @(posedge clk); while (!in_ready);
		book.note_request(row, col, b, done);
		items_sent++;
		gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every queued award has come out and the solver is quiet.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (book.awards.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(logic [4:0] sz, logic [7:0] eps, logic [15:0] rl);
		write_reg(aas_pkg::REG_SIZE, {27'd0, sz});
		write_reg(aas_pkg::REG_EPS, {24'd0, eps});
		write_reg(aas_pkg::REG_ROUNDS, {16'd0, rl});
	endtask

	function automatic logic signed [15:0] pick_benefit(bit narrow);
		if (narrow) return 16'($signed($urandom_range(0, 8)) - 4);
		return 16'($urandom_range(0, 65535));
	endfunction

	initial begin
		logic signed [15:0] b;
		int n, count;
		logic [4:0] sz;
		logic [7:0] eps;
		logic [15:0] rl;
		bit narrow;
		bit press;
		book = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		row_bidder = '0;
		col_item = '0;
		benefit = '0;
		load_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full 16x16 load first, so no later auction reads an unwritten entry.
		// The first entries carry the benefit extremes; a large epsilon keeps
		// the wide-range auction short.
		set_regs(5'd16, 8'd255, 16'd300);
		for (int r = 0; r < N_MAX; r++)
			for (int c = 0; c < N_MAX; c++) begin
				case (r * N_MAX + c)
					0: b = -16'sd32768;
					1: b = 16'sd32767;
					2: b = 16'sd0;
					3: b = -16'sd1;
					default: b = pick_benefit(0);
				endcase
				send_entry(r[3:0], c[3:0], b, (r == N_MAX - 1 && c == N_MAX - 1));
			end
		drain_results();

		// Directed corners: single item, size zero and oversize, zero epsilon,
		// zero and one round, and a price war at the benefit extremes.
		set_regs(5'd1, 8'd7, 16'd65535);
		send_entry(4'd0, 4'd0, 16'sd5, 1'b1);
		drain_results();
		set_regs(5'd0, 8'd0, 16'd20);
		send_entry(4'd0, 4'd0, -16'sd9, 1'b1);
		drain_results();
		set_regs(5'd31, 8'd255, 16'd0);
		send_entry(4'd15, 4'd15, 16'sd1, 1'b1);
		drain_results();
		set_regs(5'd17, 8'd128, 16'd1);
		send_entry(4'd3, 4'd9, 16'sd100, 1'b1);
		drain_results();
		set_regs(5'd2, 8'd0, 16'd30);
		send_entry(4'd0, 4'd1, 16'sd0, 1'b0);
		send_entry(4'd1, 4'd0, 16'sd0, 1'b0);
		send_entry(4'd1, 4'd1, 16'sd0, 1'b0);
		send_entry(4'd0, 4'd0, 16'sd0, 1'b1);
		drain_results();
		// Both bidders want item 0 by the full benefit span, so its price climbs
		// by a large step; epsilon and the round limit at their top values.
		set_regs(5'd2, 8'd255, 16'd65535);
		send_entry(4'd0, 4'd0, 16'sd32767, 1'b0);
		send_entry(4'd0, 4'd1, -16'sd32768, 1'b0);
		send_entry(4'd1, 4'd0, 16'sd32767, 1'b0);
		send_entry(4'd1, 4'd1, -16'sd32768, 1'b1);
		drain_results();

		// Random phases: some full well-formed loads of small matrices, mostly
		// scattered partial reloads; results land under a busy receiver.
		// The first random phase backs the solver up behind a held receiver.
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 5))
				0: sz = 5'($urandom_range(0, 31));
				1: sz = 5'd16;
				default: sz = 5'($urandom_range(1, 5));
			endcase
			n = (sz == 0) ? 1 : (sz > N_MAX ? N_MAX : sz);
			narrow = $urandom_range(0, 2) != 0;
			case ($urandom_range(0, 4))
				0: eps = 8'd0;
				1: eps = 8'd1;
				2: eps = 8'd255;
				default: eps = 8'($urandom_range(2, 254));
			endcase
			// Keep the auction bounded: wide benefits with a small epsilon and
			// any zero-epsilon run get a short round limit.
			if (eps == 0) rl = 16'($urandom_range(0, 40));
			else if (!narrow && eps < 64) rl = 16'($urandom_range(1, 200));
			else if ($urandom_range(0, 1)) rl = 16'd65535;
			else rl = 16'($urandom_range(1, 300));
			set_regs(sz, eps, rl);
			press = 0;
			if (hold_receiver == 0 && items_sent < 300) begin
				hold_receiver = 1;
				press = 1;
			end
			if (n <= 4 && $urandom_range(0, 2) != 0) begin
				for (int r = 0; r < n; r++)
					for (int c = 0; c < n; c++)
						send_entry(r[3:0], c[3:0], pick_benefit(narrow),
							(r == n - 1 && c == n - 1));
			end else begin
				count = $urandom_range(1, 12);
				for (int k = 0; k < count; k++)
					send_entry(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						pick_benefit(narrow), k == count - 1);
			end
			// Back-to-back phases without a drain exercise the block's own
			// input stall; registers still change only after a drain.
			if (press || $urandom_range(0, 1)) begin
				for (int k = 0; k < 3; k++)
					send_entry(4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)),
						pick_benefit(narrow), k == 2);
			end
			drain_results();
		end

		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("auction_assignment_solver_tb: done, clean");
		end else begin
			$display("auction_assignment_solver_tb: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/aas_pkg.sv
rtl/aas_ram.sv
rtl/aas_cell.sv
rtl/auction_assignment_solver.sv
rtl/aas_checker.sv
bench/auction_assignment_solver_tb.sv
